### sv/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   typedef logic [31:0] word_type;

   function automatic word_type start_word(input logic [2:0] idx);
      word_type w;
      w = '0;
      case (idx)
         3'd0: w = 32'h6A09E667;
         3'd1: w = 32'hBB67AE85;
         3'd2: w = 32'h3C6EF372;
         3'd3: w = 32'hA54FF53A;
         3'd4: w = 32'h510E527F;
         3'd5: w = 32'h9B05688C;
         3'd6: w = 32'h1F83D9AB;
         default: w = 32'h5BE0CD19;
      endcase
      return w;
   endfunction

   localparam word_type ROUND_KEYS [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

### sv/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// Streaming SHA-256: one message byte per request on req_tdata, with tlast marking the
// message end and req_tuser[0] saying whether the byte is present. A request that fills a
// 64-byte block starts a compression, the rounds and then the fold of the working
// variables into the chain value, all through one shared round unit; other requests need
// no compression. On a message end the block pads one byte per cycle (each pad byte that
// completes a block runs the same compression) and then presents the eight digest
// words on rsp_tdata, word 0 first, with rsp_tlast on word 7. req_tready is low throughout.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // msg_byte
   input  logic        req_tlast,   // message_end
   input  logic        req_tuser,   // byte_present
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [3:0]  rsp_tuser,   // word_index [2:0], final_word [3]
   output logic        rsp_tlast    // final_word
);

   sha256_pkg::state_type state_ff, state_in;

   logic [31:0] chain_ff [8];
   logic [31:0] vars_ff [8];
   logic [31:0] win_ff [16];
   logic [63:0] len_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  round_ff;
   logic [2:0]  idx_ff;
   logic        ending_ff;
   logic        mark_ff;
   logic        len_phase_ff;

   logic [7:0]  push_byte;
   logic        push_en;
   logic        accept;
   logic [31:0] wt, s0, s1, big0, big1, ch, maj, t1;
   logic [31:0] wa, wb;
   logic [3:0]  ri;
   logic [2:0]  len_sel;

   assign accept = req_tvalid && req_tready;
   assign ri = round_ff[3:0];
   assign wa = win_ff[ri + 4'd1];
   assign wb = win_ff[ri + 4'd14];
   assign s0 = sha256_pkg::rotr(wa, 7) ^ sha256_pkg::rotr(wa, 18) ^ (wa >> 3);
   assign s1 = sha256_pkg::rotr(wb, 17) ^ sha256_pkg::rotr(wb, 19) ^ (wb >> 10);
   assign wt = (round_ff < 6'd16) ? win_ff[ri]
             : win_ff[ri] + win_ff[ri + 4'd9] + s0 + s1;
   assign big1 = sha256_pkg::rotr(vars_ff[4], 6) ^ sha256_pkg::rotr(vars_ff[4], 11)
               ^ sha256_pkg::rotr(vars_ff[4], 25);
   assign big0 = sha256_pkg::rotr(vars_ff[0], 2) ^ sha256_pkg::rotr(vars_ff[0], 13)
               ^ sha256_pkg::rotr(vars_ff[0], 22);
   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[1] & vars_ff[2])
              ^ (vars_ff[2] & vars_ff[0]);
   assign t1 = vars_ff[7] + big1 + ch + sha256_pkg::ROUND_KEYS[round_ff] + wt;

   // Pad bytes: the marker, zeros up to the length field, then the length big-endian.
   assign len_sel = 3'd7 - fill_ff[2:0];
   always_comb begin
      push_byte = 8'h00;
      push_en = 1'b0;
      if (state_ff == sha256_pkg::ST_IDLE) begin
         push_byte = req_tdata;
         push_en = accept && req_tuser;
      end else if (state_ff == sha256_pkg::ST_PAD) begin
         push_en = 1'b1;
         if (!mark_ff) push_byte = sha256_pkg::PAD_MARK;
         else if (len_phase_ff) push_byte = len_ff[len_sel*8 +: 8];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (accept) begin
               if (push_en && fill_ff == 6'd63) state_in = sha256_pkg::ST_ROUND;
               else if (req_tlast) state_in = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_ROUND: begin
            if (round_ff == 6'd63) state_in = sha256_pkg::ST_FOLD;
         end
         sha256_pkg::ST_FOLD: begin
            if (idx_ff == 3'd7) begin
               if (!ending_ff) state_in = sha256_pkg::ST_IDLE;
               else if (len_phase_ff) state_in = sha256_pkg::ST_EMIT;
               else state_in = sha256_pkg::ST_PAD;
            end
         end
         sha256_pkg::ST_PAD: begin
            if (fill_ff == 6'd63) state_in = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_tready && idx_ff == 3'd7) state_in = sha256_pkg::ST_IDLE;
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sha256_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         if (fill_ff[1:0] == 2'd0) win_ff[fill_ff[5:2]] <= {push_byte, 24'h0};
         else win_ff[fill_ff[5:2]][(3 - fill_ff[1:0])*8 +: 8] <= push_byte;
      end else if (state_ff == sha256_pkg::ST_ROUND && round_ff >= 6'd16) begin
         win_ff[ri] <= wt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha256_pkg::start_word(3'(i));
         for (int i = 0; i < 8; i++) vars_ff[i] <= '0;
         len_ff <= '0;
         fill_ff <= '0;
         round_ff <= '0;
         idx_ff <= '0;
         ending_ff <= 1'b0;
         mark_ff <= 1'b0;
         len_phase_ff <= 1'b0;
      end else begin
         if (push_en) fill_ff <= fill_ff + 6'd1;
         if (state_ff == sha256_pkg::ST_IDLE && push_en) len_ff <= len_ff + 64'd8;
         if (state_ff == sha256_pkg::ST_IDLE && accept && req_tlast) ending_ff <= 1'b1;
         if (state_ff == sha256_pkg::ST_PAD && !mark_ff) mark_ff <= 1'b1;
         // Once the pad reaches the byte before the length field, the length follows.
         if (state_ff == sha256_pkg::ST_PAD && fill_ff == sha256_pkg::LEN_START - 6'd1)
            len_phase_ff <= 1'b1;
         if (state_in == sha256_pkg::ST_ROUND && state_ff != sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < 8; i++) vars_ff[i] <= chain_ff[i];
            round_ff <= '0;
         end
         if (state_ff == sha256_pkg::ST_ROUND) begin
            vars_ff[7] <= vars_ff[6];
            vars_ff[6] <= vars_ff[5];
            vars_ff[5] <= vars_ff[4];
            vars_ff[4] <= vars_ff[3] + t1;
            vars_ff[3] <= vars_ff[2];
            vars_ff[2] <= vars_ff[1];
            vars_ff[1] <= vars_ff[0];
            vars_ff[0] <= t1 + big0 + maj;
            round_ff <= round_ff + 6'd1;
            idx_ff <= '0;
         end
         if (state_ff == sha256_pkg::ST_FOLD) begin
            chain_ff[idx_ff] <= chain_ff[idx_ff] + vars_ff[idx_ff];
            idx_ff <= idx_ff + 3'd1;
         end
         if (state_ff == sha256_pkg::ST_EMIT && rsp_tready) begin
            idx_ff <= idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= sha256_pkg::start_word(3'(i));
               for (int i = 0; i < 8; i++) vars_ff[i] <= '0;
               len_ff <= '0;
               fill_ff <= '0;
               ending_ff <= 1'b0;
               mark_ff <= 1'b0;
               len_phase_ff <= 1'b0;
            end
         end
      end
   end

   assign req_tready = (state_ff == sha256_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == sha256_pkg::ST_EMIT);
   assign rsp_tdata  = chain_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == 3'd7);
   assign rsp_tuser  = {rsp_tlast, idx_ff};

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256_pkg::ST_ROUND) |-> !req_tready && !rsp_tvalid)
      else $error("request taken during compression");
   a_round_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256_pkg::ST_ROUND && round_ff == 6'd63) |=>
      state_ff == sha256_pkg::ST_FOLD && idx_ff == 3'd0)
      else $error("compression did not fold after 64 rounds");
   a_emit_block_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fill_ff == 6'd0)
      else $error("digest shown with partial block");

endmodule

### test/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_present;
      logic       message_end;
   } request_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } digest_out_type;

   // One directed row: the request and, on a message end, an optional known digest.
   typedef struct packed {
      logic [7:0]  msg_byte;
      logic        byte_present;
      logic        message_end;
      logic        check;
      logic [31:0] w0;
      logic [31:0] w7;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 15;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'hE3B0C442, 32'h7852B855},
      '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h63, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'hBA7816BF, 32'hF20015AD},
      '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, 32'hBA7816BF, 32'hF20015AD},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'hAA, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h55, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'hE3B0C442, 32'h7852B855}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   sha256_stream_hasher DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // Hash state of the predictor.
   logic [31:0] hash_chain [8];
   logic [31:0] block_words [16];
   logic [63:0] msg_bits;
   int          block_bytes;

   digest_out_type digest_queue [$];
   int  failures = 0;
   int  digests_seen = 0;
   int  cycle_count = 0;
   bit  stimulus_done = 1'b0;
   bit  long_hold = 1'b0;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) hash_chain[i] = INIT_HASH[i];
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      msg_bits = '0;
      block_bytes = 0;
   endtask

   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 16; t++) w[t] = block_words[t];
      for (int t = 16; t < 64; t++)
         w[t] = w[t-16] + w[t-7]
            + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
            + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_KEYS[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      block_words[block_bytes / 4][8 * (3 - block_bytes % 4) +: 8] = b;
      block_bytes++;
      if (block_bytes == 64) begin
         compress();
         block_bytes = 0;
      end
   endtask

   task automatic predict_digest(input request_type r);
      digest_out_type d;
      if (r.byte_present) begin
         absorb_byte(r.msg_byte);
         msg_bits += 64'd8;
      end
      if (r.message_end) begin
         absorb_byte(sha256_pkg::PAD_MARK);
         while (block_bytes != 56) absorb_byte(8'h00);
         for (int k = 7; k >= 0; k--) absorb_byte(msg_bits[8 * k +: 8]);
         for (int k = 0; k < 8; k++) begin
            d.digest_word = hash_chain[k];
            d.word_index = k[2:0];
            d.final_word = (k == 7);
            digest_queue.push_back(d);
         end
         hash_restart();
      end
   endtask

   // Known digests of short messages, checked in addition to the predictor.
   task automatic check_known(input logic [31:0] w0, input logic [31:0] w7);
      if (digest_queue.size() >= 8 &&
          (digest_queue[digest_queue.size()-8].digest_word !== w0 ||
           digest_queue[digest_queue.size()-1].digest_word !== w7)) begin
         $error("known digest: expected %h..%h, got %h..%h", w0, w7,
                digest_queue[digest_queue.size()-8].digest_word,
                digest_queue[digest_queue.size()-1].digest_word);
         failures++;
      end
   endtask

   task automatic send(input request_type r);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= r.msg_byte;
      req_tuser <= r.byte_present;
      req_tlast <= r.message_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_digest(r);
      @(negedge clock);
   endtask

   function automatic request_type mk(input logic [7:0] b, input bit p, input bit e);
      request_type r;
      r.msg_byte = b; r.byte_present = p; r.message_end = e;
      return r;
   endfunction

   // Stimulus.
   initial begin
      request_type r;
      int len;
      hash_restart();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message, "abc", idle requests, byte with end, extremes.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send(mk(DIRECTED[i].msg_byte, DIRECTED[i].byte_present, DIRECTED[i].message_end));
         if (DIRECTED[i].check) check_known(DIRECTED[i].w0, DIRECTED[i].w7);
      end

      // Random: whole messages of varied length, some near the
      // 55, 56 and 64 byte padding boundaries.
      for (int m = 0; m < 10; m++) begin
         case (m)
            0: len = 55;
            1: len = 56;
            2: len = 64;
            default: len = $urandom_range(0, 6);
         endcase
         if (m == 3) long_hold = 1'b1;
         for (int i = 0; i < len; i++) begin
            r = mk(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            if ($urandom_range(0, 9) == 0) r.byte_present = 1'b0;
            send(r);
         end
         send(mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver with random stalls and one long hold-off.
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      digest_out_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            $error("unexpected digest word %h", rsp_tdata);
            failures++;
         end else begin
            e = digest_queue.pop_front();
            digests_seen++;
            if (rsp_tdata !== e.digest_word) begin
               $error("digest_word: expected %h, got %h", e.digest_word, rsp_tdata);
               failures++;
            end
            if (rsp_tuser[2:0] !== e.word_index) begin
               $error("word_index: expected %0d, got %0d", e.word_index, rsp_tuser[2:0]);
               failures++;
            end
            if (rsp_tuser[3] !== e.final_word || rsp_tlast !== e.final_word) begin
               $error("final_word: expected %0b, got %0b/%0b", e.final_word,
                      rsp_tuser[3], rsp_tlast);
               failures++;
            end
         end
      end
   end

   initial begin
      wait (stimulus_done && digest_queue.size() == 0);
      repeat (200) @(posedge clock);
      $display("Checked %0d digest words across short, boundary-length and two-block messages,",
               digests_seen);
      $display("with empty messages, idle requests and a long output stall.");
      if (failures == 0 && digest_queue.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
   end

endmodule
